[rtl/core/hmtm_pkg.sv]
// Shared types and constants for the temporary mapping slot table.
// Used by hmtm_ctrl, hmtm_dpath and highmem_temp_map_slot_table.
`default_nettype none

package hmtm_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;
    localparam logic [31:0] PTE_VALID  = 32'h0000_0001;
    localparam logic [31:0] PTE_WRITE  = 32'h0000_0002;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    localparam logic [1:0] ST_BYPASS  = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_LIMIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MAP_OFFSET = 2'd2;

    localparam logic [31:0] RST_WINDOW_BASE       = 32'h0000_0000;
    localparam logic [31:0] RST_BYPASS_LIMIT      = 32'h3800_0000;
    localparam logic [31:0] RST_DIRECT_MAP_OFFSET = 32'hC000_0000;

    typedef struct packed {
        logic        opcode;
        logic [31:0] page_addr;
    } t_req;

    typedef struct packed {
        logic [31:0] virt_addr;
        logic [31:0] pte_value;
        logic        pte_write;
        logic [3:0]  slot_index;
        logic [1:0]  status;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic resolve;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/hmtm_ctrl.sv]
// Request sequencer for the slot table: accept a request, then resolve it.
// Depends on hmtm_pkg for the command struct.
`default_nettype none

module hmtm_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    output hmtm_pkg::t_cmd  o_cmd
);

    localparam logic S_IDLE    = 1'b0;
    localparam logic S_RESOLVE = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state == S_RESOLVE);
    assign o_cmd.capture = start && (r_state == S_IDLE);
    assign o_cmd.resolve = (r_state == S_RESOLVE);

endmodule

`default_nettype wire

[rtl/core/hmtm_dpath.sv]
// Datapath of the slot table: config registers, slot store, parallel
// compare, lowest-match select, slot update and result register.
// Depends on hmtm_pkg.
`default_nettype none

module hmtm_dpath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  hmtm_pkg::t_cmd                   i_cmd,
    input  hmtm_pkg::t_req                   i_req,
    input  wire                              i_cfg_we,
    input  wire [hmtm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [31:0]                       i_cfg_data,
    output logic                             o_result_valid,
    output hmtm_pkg::t_result                o_result
);

    logic [31:0] r_window_base;
    logic [31:0] r_bypass_limit;
    logic [31:0] r_direct_map_offset;

    logic [31:0] r_slot [hmtm_pkg::SLOT_COUNT];

    logic                            r_op;
    logic [31:0]                     r_pa;
    logic                            r_bypass;
    logic [hmtm_pkg::SLOT_COUNT-1:0] r_match;

    logic [31:0]                     want;
    logic [hmtm_pkg::SLOT_COUNT-1:0] n_match;
    logic [hmtm_pkg::SLOT_COUNT-1:0] lowest;
    logic [hmtm_pkg::SLOT_W-1:0]     hit_idx;
    logic                            found;
    logic [31:0]                     slot_va;
    hmtm_pkg::t_result               n_result;
    logic                            do_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base       <= hmtm_pkg::RST_WINDOW_BASE;
            r_bypass_limit      <= hmtm_pkg::RST_BYPASS_LIMIT;
            r_direct_map_offset <= hmtm_pkg::RST_DIRECT_MAP_OFFSET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == hmtm_pkg::CFG_WINDOW_BASE) begin
                r_window_base <= i_cfg_data;
            end
            if (i_cfg_index == hmtm_pkg::CFG_BYPASS_LIMIT) begin
                r_bypass_limit <= i_cfg_data;
            end
            if (i_cfg_index == hmtm_pkg::CFG_DIRECT_MAP_OFFSET) begin
                r_direct_map_offset <= i_cfg_data;
            end
        end
    end

    // A map looks for a free (zero) slot, an unmap for the address itself.
    assign want = (i_req.opcode == hmtm_pkg::OP_MAP) ? 32'd0 : i_req.page_addr;

    always_comb begin
        for (int k = 0; k < hmtm_pkg::SLOT_COUNT; k++) begin
            n_match[k] = (r_slot[k] == want);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_req.opcode;
            r_pa     <= i_req.page_addr;
            r_bypass <= (i_req.page_addr < r_bypass_limit);
            r_match  <= n_match;
        end
    end

    // Isolate the lowest matching slot, then encode it.
    assign lowest = r_match & (~r_match + hmtm_pkg::SLOT_COUNT'(1));
    assign found  = |r_match;

    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < hmtm_pkg::SLOT_COUNT; k++) begin
            if (lowest[k]) begin
                hit_idx = hit_idx | hmtm_pkg::SLOT_W'(k);
            end
        end
    end

    assign slot_va  = r_window_base + (32'(hit_idx) << hmtm_pkg::PAGE_SHIFT);
    assign do_write = i_cmd.resolve && !r_bypass && found;

    always_comb begin
        n_result = '0;
        if (r_bypass) begin
            n_result.virt_addr = r_pa + r_direct_map_offset;
            n_result.status    = hmtm_pkg::ST_BYPASS;
        end else if (found) begin
            n_result.virt_addr  = slot_va;
            n_result.pte_write  = 1'b1;
            n_result.slot_index = 4'(hit_idx);
            n_result.status     = hmtm_pkg::ST_DONE;
            if (r_op == hmtm_pkg::OP_MAP) begin
                n_result.pte_value = (r_pa & hmtm_pkg::FRAME_MASK)
                                   | hmtm_pkg::PTE_VALID | hmtm_pkg::PTE_WRITE;
            end
        end else begin
            n_result.status = (r_op == hmtm_pkg::OP_MAP) ? hmtm_pkg::ST_FULL
                                                         : hmtm_pkg::ST_MISSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < hmtm_pkg::SLOT_COUNT; k++) begin
                r_slot[k] <= 32'd0;
            end
        end else if (do_write) begin
            for (int k = 0; k < hmtm_pkg::SLOT_COUNT; k++) begin
                if (lowest[k]) begin
                    r_slot[k] <= (r_op == hmtm_pkg::OP_MAP) ? r_pa : 32'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.resolve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            o_result <= n_result;
        end
    end

endmodule

`default_nettype wire

[rtl/core/highmem_temp_map_slot_table.sv]
// Top level of the temporary mapping slot table.
// Joins hmtm_ctrl and hmtm_dpath; depends on hmtm_pkg.
//
// Usage:
//   Request channel: drive i_req (opcode, page_addr) and raise start; the
//   beat is taken at a clock edge where start is high and busy is low.
//   busy is high for one cycle after a beat is taken.
//   Result channel: o_result_valid strobes for one cycle with o_result.
//   There is no backpressure; the receiver must take every result beat.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Index 0 window_base,
//   1 bypass_limit, 2 direct_map_offset; index 3 is ignored. Write only
//   while no request is in flight.
//   Sequence: the compare step matches all slots against the request and
//   registers the matches; the select-and-update step then picks the lowest
//   match, updates the slot and registers the result. A new request is not
//   taken while busy, i.e. during the select-and-update step.
//   Reset (synchronous, active low): all slots free, config registers to
//   their defaults, no result pending. Ready for requests right after.
`default_nettype none

module highmem_temp_map_slot_table (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  hmtm_pkg::t_req                   i_req,
    output logic                             o_result_valid,
    output hmtm_pkg::t_result                o_result,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [hmtm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [31:0]                       i_cfg_data
);

    hmtm_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    hmtm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    hmtm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire

[dv/highmem_temp_map_slot_table_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for highmem_temp_map_slot_table: directed and random map/unmap
// requests, config writes between phases, results checked against a slot table shadow.
// Depends on hmtm_pkg and the highmem_temp_map_slot_table RTL.

module highmem_temp_map_slot_table_tb;
    import hmtm_pkg::*;

    localparam int STALL_LIMIT = 500;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_REQS  = 105;
    localparam int MAX_PRINTS  = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          data;
        t_req                 req;
    } t_stim_beat;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    t_req                 req;
    logic                 res_valid;
    t_result              res;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Shadow of the block's registers and slot table.
    logic [31:0] win_base;
    logic [31:0] low_limit;
    logic [31:0] dmap_off;
    logic [31:0] slot_owner [SLOT_COUNT];

    t_stim_beat  pending_beats [$];
    t_result     expected_results [$];
    logic [31:0] addr_pool [$];
    logic [31:0] gen_limit;

    bit req_taken;
    bit cfg_taken;
    bit stalled;
    int req_total;
    int cfg_total;
    int reqs_sent;
    int results_seen;
    int cfg_done;
    int err_count;
    int quiet_cycles;
    int status_count [4];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    highmem_temp_map_slot_table dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req),
        .o_result_valid (res_valid),
        .o_result       (res),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH result %0d: %s got 0x%08h want 0x%08h",
                     results_seen, what, got, want);
        err_count++;
    endtask

    // Work out one request's result and update the slot shadow.
    function automatic t_result predict_mapping(input t_req rq);
        t_result     r;
        logic [31:0] match;
        bit          hit;
        int          s;
        r   = '0;
        hit = 1'b0;
        if (rq.page_addr < low_limit) begin
            r.virt_addr = rq.page_addr + dmap_off;
            r.status    = ST_BYPASS;
        end else begin
            // a map looks for a free slot, an unmap for the address itself
            match    = (rq.opcode == OP_MAP) ? 32'h0 : rq.page_addr;
            r.status = (rq.opcode == OP_MAP) ? ST_FULL : ST_MISSING;
            for (s = 0; s < SLOT_COUNT; s++) begin
                if (!hit && slot_owner[s] === match) begin
                    hit          = 1'b1;
                    r.virt_addr  = win_base + (32'(s) << PAGE_SHIFT);
                    r.pte_write  = 1'b1;
                    r.slot_index = 4'(s);
                    r.status     = ST_DONE;
                    if (rq.opcode == OP_MAP) begin
                        slot_owner[s] = rq.page_addr;
                        r.pte_value   = (rq.page_addr & FRAME_MASK) | PTE_VALID | PTE_WRITE;
                    end else begin
                        slot_owner[s] = 32'h0;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic queue_req(input logic op, input logic [31:0] addr);
        t_stim_beat b;
        b.is_cfg        = 1'b0;
        b.idx           = '0;
        b.data          = '0;
        b.req.opcode    = op;
        b.req.page_addr = addr;
        pending_beats.push_back(b);
        req_total++;
    endtask

    task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        t_stim_beat b;
        b.is_cfg = 1'b1;
        b.idx    = idx;
        b.data   = data;
        b.req    = '0;
        pending_beats.push_back(b);
        cfg_total++;
        if (idx == CFG_BYPASS_LIMIT)
            gen_limit = data;
    endtask

    function automatic void remember_addr(input logic [31:0] a);
        addr_pool.push_back(a);
        if (addr_pool.size() > 24)
            void'(addr_pool.pop_front());
    endfunction

    // Bias unmaps toward recently drawn addresses so that they can hit mapped slots.
    function automatic logic [31:0] pick_phys(input logic op);
        int unsigned roll;
        logic [31:0] a;
        roll = $urandom_range(0, 99);
        if (roll < 18 && gen_limit != 32'h0) begin
            a = $urandom_range(0, gen_limit - 1);
        end else if (roll < 26) begin
            case ($urandom_range(0, 3))
                0:       a = 32'h0;
                1:       a = 32'hFFFF_FFFF;
                2:       a = gen_limit;
                default: a = gen_limit - 1;
            endcase
        end else if (addr_pool.size() > 0 && roll < ((op == OP_UNMAP) ? 80 : 45)) begin
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        end else begin
            a = gen_limit + $urandom_range(0, ~gen_limit);
            remember_addr(a);
        end
        return a;
    endfunction

    // Driver: one beat at a time, request or register write.
    always @(negedge clk) begin
        t_stim_beat           nb;
        logic                 held;
        logic                 n_start;
        logic                 n_cfg_v;
        t_req                 n_req;
        logic [CFG_IDX_W-1:0] n_idx;
        logic [31:0]          n_data;
        int                   gap_pct;
        held      = (start && !req_taken) || (cfg_valid && !cfg_taken);
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        n_start   = held & start;
        n_cfg_v   = held & cfg_valid;
        n_req     = req;
        n_idx     = cfg_index;
        n_data    = cfg_data;
        gap_pct   = (reqs_sent >= 250 && reqs_sent < 400) ? 0 : 28;
        if (!held) begin
            // scramble the idle bus
            n_req.opcode    = 1'($urandom);
            n_req.page_addr = $urandom;
            n_idx           = CFG_IDX_W'($urandom);
            n_data          = $urandom;
            if (rst_n && pending_beats.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                nb = pending_beats[0];
                if (!nb.is_cfg) begin
                    void'(pending_beats.pop_front());
                    n_start = 1'b1;
                    n_req   = nb.req;
                end else if (expected_results.size() == 0) begin
                    // write registers only with nothing in flight
                    void'(pending_beats.pop_front());
                    n_cfg_v = 1'b1;
                    n_idx   = nb.idx;
                    n_data  = nb.data;
                end
            end
        end
        start     <= n_start;
        cfg_valid <= n_cfg_v;
        req       <= n_req;
        cfg_index <= n_idx;
        cfg_data  <= n_data;
    end

    // Monitor: predict on accepted requests, check result beats, watch for a hang.
    always @(posedge clk) begin
        t_result want;
        bit      active;
        active = 1'b0;
        if (rst_n) begin
            if (start && !busy) begin
                want = predict_mapping(req);
                expected_results.push_back(want);
                status_count[want.status]++;
                req_taken = 1'b1;
                reqs_sent++;
                active = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_BASE:       win_base  = cfg_data;
                    CFG_BYPASS_LIMIT:      low_limit = cfg_data;
                    CFG_DIRECT_MAP_OFFSET: dmap_off  = cfg_data;
                    default: ;
                endcase
                cfg_taken = 1'b1;
                cfg_done++;
                active = 1'b1;
            end
            if (res_valid) begin
                active = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, virt_addr", res.virt_addr, 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (res.virt_addr !== want.virt_addr)
                        report_mismatch("virt_addr", res.virt_addr, want.virt_addr);
                    if (res.pte_value !== want.pte_value)
                        report_mismatch("pte_value", res.pte_value, want.pte_value);
                    if (res.pte_write !== want.pte_write)
                        report_mismatch("pte_write", 32'(res.pte_write), 32'(want.pte_write));
                    if (res.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 32'(res.slot_index), 32'(want.slot_index));
                    if (res.status !== want.status)
                        report_mismatch("status", 32'(res.status), 32'(want.status));
                    results_seen++;
                end
            end
            quiet_cycles = active ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
                stalled = 1'b1;
        end
    end

    initial begin
        int ph;
        int n;
        logic op;
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_valid    = 1'b0;
        req          = '0;
        cfg_index    = '0;
        cfg_data     = '0;
        win_base     = RST_WINDOW_BASE;
        low_limit    = RST_BYPASS_LIMIT;
        dmap_off     = RST_DIRECT_MAP_OFFSET;
        gen_limit    = RST_BYPASS_LIMIT;
        for (n = 0; n < SLOT_COUNT; n++)
            slot_owner[n] = 32'h0;
        for (n = 0; n < 4; n++)
            status_count[n] = 0;

        // Directed: bypass at both ends, slot map/unmap, miss, full table, reuse.
        queue_req(OP_MAP, 32'h0);
        queue_req(OP_MAP, RST_BYPASS_LIMIT - 1);
        queue_req(OP_UNMAP, 32'h0000_1234);
        queue_req(OP_MAP, RST_BYPASS_LIMIT);
        queue_req(OP_MAP, 32'hFFFF_FFFF);
        queue_req(OP_UNMAP, 32'hFFFF_FFFF);
        queue_req(OP_UNMAP, 32'h5000_0000);
        for (n = 1; n < SLOT_COUNT; n++) begin
            queue_req(OP_MAP, 32'h4000_0000 + (n << PAGE_SHIFT) + n);
            remember_addr(32'h4000_0000 + (n << PAGE_SHIFT) + n);
        end
        queue_req(OP_MAP, 32'h6000_0000);
        queue_req(OP_UNMAP, 32'h4000_0000 + (7 << PAGE_SHIFT) + 7);

        // Random phases, each under its own register settings.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    queue_cfg(CFG_WINDOW_BASE, 32'hFFFF_F000);
                    queue_cfg(CFG_BYPASS_LIMIT, 32'h0);
                    queue_cfg(CFG_DIRECT_MAP_OFFSET, 32'hFFFF_FFFF);
                    queue_cfg(CFG_UNUSED, $urandom);
                end
                1: begin
                    queue_cfg(CFG_WINDOW_BASE, $urandom & FRAME_MASK);
                    queue_cfg(CFG_BYPASS_LIMIT, 32'hFFFF_FFFF);
                    queue_cfg(CFG_DIRECT_MAP_OFFSET, 32'h0);
                end
                2: begin
                    queue_cfg(CFG_WINDOW_BASE, $urandom);
                    queue_cfg(CFG_BYPASS_LIMIT, $urandom);
                    queue_cfg(CFG_DIRECT_MAP_OFFSET, $urandom);
                end
                3: begin
                    queue_cfg(CFG_WINDOW_BASE, 32'h0);
                    queue_cfg(CFG_BYPASS_LIMIT, 32'h8000_0000);
                    queue_cfg(CFG_DIRECT_MAP_OFFSET, $urandom);
                end
                4: begin
                    queue_cfg(CFG_WINDOW_BASE, 32'h7FFF_F000);
                    queue_cfg(CFG_BYPASS_LIMIT, $urandom_range(0, 32'h1000_0000));
                end
                default: begin
                    queue_cfg(CFG_WINDOW_BASE, RST_WINDOW_BASE);
                    queue_cfg(CFG_BYPASS_LIMIT, RST_BYPASS_LIMIT);
                    queue_cfg(CFG_DIRECT_MAP_OFFSET, RST_DIRECT_MAP_OFFSET);
                end
            endcase
            for (n = 0; n < PHASE_REQS; n++) begin
                op = 1'($urandom_range(0, 1));
                queue_req(op, pick_phys(op));
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!stalled && (results_seen < req_total || cfg_done < cfg_total))
            @(negedge clk);
        if (stalled) begin
            $display("stalled: %0d of %0d results after %0d idle cycles",
                     results_seen, req_total, STALL_LIMIT);
            $display("highmem_temp_map_slot_table_tb: errors");
            $finish;
        end else begin
            // let any stray result beat show up
            repeat (6) @(negedge clk);
            $display("checked %0d requests: %0d bypass, %0d slot hits, %0d full, %0d missing",
                     results_seen, status_count[ST_BYPASS], status_count[ST_DONE],
                     status_count[ST_FULL], status_count[ST_MISSING]);
            $display("%0d register writes across %0d phases, %0d mismatches",
                     cfg_done, RAND_PHASES + 1, err_count);
            if (err_count == 0)
                $display("highmem_temp_map_slot_table_tb: clean");
            else
                $display("highmem_temp_map_slot_table_tb: errors");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/core/hmtm_pkg.sv
rtl/core/hmtm_ctrl.sv
rtl/core/hmtm_dpath.sv
rtl/core/highmem_temp_map_slot_table.sv
dv/highmem_temp_map_slot_table_tb.sv
